// ===== hdl/etsf_pkg.sv =====
// Shared types and constants for the encoder throttle and switch framer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package etsf_pkg;

   // Operation codes of the input transaction.
   localparam logic [1:0] OP_B_EDGE = 2'd0;
   localparam logic [1:0] OP_A_EDGE = 2'd1;
   localparam logic [1:0] OP_POLL   = 2'd2;

   // Configuration register indexes and reset values.
   localparam int                   CSR_IDX_W         = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_START   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_KIND    = 8'd1;
   localparam logic [7:0]           RESET_FRAME_START = 8'hA5;
   localparam logic [7:0]           RESET_FRAME_KIND  = 8'h03;

   // Position value that means the lever is held.
   localparam logic [7:0] POS_HOLD = 8'd255;

   // Frame byte positions.
   localparam int               IDX_W         = 3;
   localparam logic [IDX_W-1:0] BYTE_START    = 3'd0;
   localparam logic [IDX_W-1:0] BYTE_KIND     = 3'd1;
   localparam logic [IDX_W-1:0] BYTE_SIGNALS  = 3'd3;
   localparam logic [IDX_W-1:0] BYTE_NAV      = 3'd4;
   localparam logic [IDX_W-1:0] BYTE_THROTTLE = 3'd6;

   // Frame queue sizing.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   // Room for the queue fill plus the two pipeline stages.
   localparam int CREDIT_W    = QCNT_W + 1;

   typedef struct packed {
      logic [4:0] signals;
      logic [4:0] nav;
      logic [7:0] throttle;
   } frame_type;

   typedef struct packed {
      logic      push;
      frame_type data;
   } push_type;

   typedef struct packed {
      logic      valid;
      frame_type data;
   } head_type;

endpackage

`default_nettype wire

// ===== hdl/etsf_front.sv =====
// Front end: accepts transactions, tracks the encoder count and classifies polls,
// then runs the throttle update pipeline and pushes frame contents. Uses etsf_pkg.
`default_nettype none

module etsf_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [1:0]                req_operation,
   input  wire logic [4:0]                req_signal_pins,
   input  wire logic [4:0]                req_nav_pins,
   input  wire logic [etsf_pkg::QCNT_W-1:0] queue_count,
   output etsf_pkg::push_type             push
);

   function automatic logic signed [9:0] wrap_step(input logic [7:0] cur,
                                                   input logic [7:0] want);
      logic signed [9:0] c;
      logic signed [9:0] w;
      logic signed [9:0] up;
      logic signed [9:0] down;
      logic signed [9:0] diff;
      logic signed [9:0] r;
      logic [6:0]        up7;
      logic [6:0]        down7;
      c     = signed'({2'b00, cur});
      w     = signed'({2'b00, want});
      up7   = cur[6:0] + 7'd63;
      down7 = cur[6:0] - 7'd64;
      up    = signed'({3'b000, up7});
      // Below 64 the remainder of a negative value keeps its sign.
      down  = (cur[7] | cur[6]) ? signed'({3'b000, down7}) : (c - 10'sd64);
      diff  = w - c;
      if (up > c) begin
         if ((w <= up && w >= c) || (w < c)) r = diff;
         else r = diff - 10'sd128;
      end else begin
         if ((w <= c && w >= down) || (c < w)) r = diff;
         else r = diff + 10'sd128;
      end
      return r;
   endfunction

   logic accept;
   logic [15:0] edge_count_ff, edge_count_in;
   logic        b_armed_ff, b_armed_in;
   logic [4:0]  prev_signals_ff, prev_signals_in;
   logic [4:0]  prev_nav_ff, prev_nav_in;
   logic [7:0]  prev_position_ff, prev_position_in;
   logic        has_started_ff, has_started_in;
   logic [7:0]  tracked_ff, tracked_in;
   logic [7:0]  throttle_ff, throttle_in;

   logic        s1_valid_ff, s1_valid_in;
   logic [4:0]  s1_signals_ff, s1_signals_in;
   logic [4:0]  s1_nav_ff, s1_nav_in;
   logic        s1_neg_ff, s1_neg_in;
   logic [8:0]  s1_mag_ff, s1_mag_in;

   logic        s2_valid_ff;
   logic [4:0]  s2_signals_ff;
   logic [4:0]  s2_nav_ff;
   logic        s2_neg_ff;
   logic [17:0] s2_square_ff, s2_square_in;

   logic [4:0]  sig;
   logic [4:0]  nav;
   logic [7:0]  pos;
   logic [7:0]  want;
   logic        changed;
   logic signed [9:0] step;
   logic signed [9:0] step_abs;
   logic [18:0] level_sum;
   logic [etsf_pkg::CREDIT_W-1:0] credit;

   // Stall once every queue slot is either filled or claimed by a frame in the pipeline.
   always_comb begin
      credit = etsf_pkg::CREDIT_W'(queue_count) + etsf_pkg::CREDIT_W'(s1_valid_ff)
             + etsf_pkg::CREDIT_W'(s2_valid_ff);
      req_stall = credit >= etsf_pkg::CREDIT_W'(etsf_pkg::QUEUE_DEPTH);
   end

   assign accept = req_valid && !req_stall;

   always_comb begin
      sig = ~req_signal_pins;
      nav = ~req_nav_pins;
      if (edge_count_ff[15]) pos = 8'd0;
      else if (|edge_count_ff[14:8]) pos = 8'd255;
      else pos = edge_count_ff[7:0];
      changed = (sig != prev_signals_ff) || (nav != prev_nav_ff) || (pos != prev_position_ff);
      want = (pos == etsf_pkg::POS_HOLD) ? tracked_ff : pos;
      step = has_started_ff ? wrap_step(tracked_ff, want) : 10'sd0;
      step_abs = step[9] ? -step : step;
   end

   always_comb begin
      edge_count_in    = edge_count_ff;
      b_armed_in       = b_armed_ff;
      prev_signals_in  = prev_signals_ff;
      prev_nav_in      = prev_nav_ff;
      prev_position_in = prev_position_ff;
      has_started_in   = has_started_ff;
      tracked_in       = tracked_ff;
      s1_valid_in      = 1'b0;
      s1_signals_in    = sig;
      s1_nav_in        = nav;
      s1_neg_in        = step[9];
      s1_mag_in        = step_abs[8:0];
      if (accept) begin
         case (req_operation)
            etsf_pkg::OP_B_EDGE: begin
               if (!b_armed_ff) edge_count_in = edge_count_ff + 16'd1;
               else b_armed_in = 1'b0;
            end
            etsf_pkg::OP_A_EDGE: begin
               edge_count_in = edge_count_ff - 16'd1;
               b_armed_in    = 1'b1;
            end
            etsf_pkg::OP_POLL: begin
               prev_signals_in  = sig;
               prev_nav_in      = nav;
               prev_position_in = pos;
               if (changed) begin
                  has_started_in = 1'b1;
                  tracked_in     = want;
                  s1_valid_in    = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign s2_square_in = {9'd0, s1_mag_ff} * {9'd0, s1_mag_ff};

   // Saturating throttle update in the last stage.
   always_comb begin
      level_sum   = {11'd0, throttle_ff} + {1'b0, s2_square_ff};
      throttle_in = throttle_ff;
      if (s2_valid_ff) begin
         if (s2_neg_ff) begin
            if (s2_square_ff > {10'd0, throttle_ff}) throttle_in = 8'd0;
            else throttle_in = throttle_ff - s2_square_ff[7:0];
         end else begin
            if (level_sum > 19'd255) throttle_in = 8'd255;
            else throttle_in = level_sum[7:0];
         end
      end
   end

   always_comb begin
      push.push          = s2_valid_ff;
      push.data.signals  = s2_signals_ff;
      push.data.nav      = s2_nav_ff;
      push.data.throttle = throttle_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_count_ff    <= '0;
         b_armed_ff       <= 1'b0;
         prev_signals_ff  <= '0;
         prev_nav_ff      <= '0;
         prev_position_ff <= '0;
         has_started_ff   <= 1'b0;
         tracked_ff       <= '0;
         throttle_ff      <= '0;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
      end else begin
         edge_count_ff    <= edge_count_in;
         b_armed_ff       <= b_armed_in;
         prev_signals_ff  <= prev_signals_in;
         prev_nav_ff      <= prev_nav_in;
         prev_position_ff <= prev_position_in;
         has_started_ff   <= has_started_in;
         tracked_ff       <= tracked_in;
         throttle_ff      <= throttle_in;
         s1_valid_ff      <= s1_valid_in;
         s2_valid_ff      <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_signals_ff <= s1_signals_in;
      s1_nav_ff     <= s1_nav_in;
      s1_neg_ff     <= s1_neg_in;
      s1_mag_ff     <= s1_mag_in;
      s2_signals_ff <= s1_signals_ff;
      s2_nav_ff     <= s1_nav_ff;
      s2_neg_ff     <= s1_neg_ff;
      s2_square_ff  <= s2_square_in;
   end

endmodule

`default_nettype wire

// ===== hdl/etsf_queue.sv =====
// Short frame queue between the front end and the byte serialiser.
// Uses etsf_pkg for the entry type and depth.
`default_nettype none

module etsf_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  etsf_pkg::push_type               push,
   input  wire logic                        pop,
   output etsf_pkg::head_type               head,
   output logic [etsf_pkg::QCNT_W-1:0]      count
);

   etsf_pkg::frame_type entry_ff [etsf_pkg::QUEUE_DEPTH];
   logic [etsf_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [etsf_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [etsf_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_pop;

   // The front end never pushes without a free slot.
   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push.push ? wr_ptr_ff + etsf_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + etsf_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + etsf_pkg::QCNT_W'(push.push) - etsf_pkg::QCNT_W'(do_pop);
   end

   always_comb begin
      head.valid = count_ff != '0;
      head.data  = entry_ff[rd_ptr_ff];
      count      = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) entry_ff[wr_ptr_ff] <= push.data;
   end

endmodule

`default_nettype wire

// ===== hdl/etsf_back.sv =====
// Back end: takes queued frames and sends them out one byte per transaction
// through a registered output stage. Uses etsf_pkg.
`default_nettype none

module etsf_back (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  frame_start,
   input  wire logic [7:0]  frame_kind,
   input  etsf_pkg::head_type head,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_frame_byte,
   output logic             rsp_last_byte
);

   logic                          load;
   logic                          active_ff, active_in;
   logic [etsf_pkg::IDX_W-1:0]    idx_ff, idx_in;
   etsf_pkg::frame_type           frame_ff, frame_in;
   logic                          out_valid_ff, out_valid_in;
   logic [7:0]                    byte_ff, byte_in;
   logic                          last_ff, last_in;
   logic [7:0]                    sel_byte;

   assign load = !out_valid_ff || !rsp_stall;
   assign pop  = load && !active_ff && head.valid;

   // The padding bytes fall to the default arm and are sent as zero.
   always_comb begin
      case (idx_ff)
         etsf_pkg::BYTE_KIND:     sel_byte = frame_kind;
         etsf_pkg::BYTE_SIGNALS:  sel_byte = {3'b000, frame_ff.signals};
         etsf_pkg::BYTE_NAV:      sel_byte = {3'b000, frame_ff.nav};
         etsf_pkg::BYTE_THROTTLE: sel_byte = frame_ff.throttle;
         default:                 sel_byte = 8'd0;
      endcase
   end

   always_comb begin
      active_in    = active_ff;
      idx_in       = idx_ff;
      frame_in     = frame_ff;
      out_valid_in = out_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      if (load) begin
         if (active_ff) begin
            out_valid_in = 1'b1;
            byte_in      = sel_byte;
            last_in      = idx_ff == etsf_pkg::BYTE_THROTTLE;
            idx_in       = idx_ff + etsf_pkg::IDX_W'(1);
            if (idx_ff == etsf_pkg::BYTE_THROTTLE) active_in = 1'b0;
         end else if (head.valid) begin
            // The start byte needs no frame data, so it goes out as the entry is taken.
            frame_in     = head.data;
            out_valid_in = 1'b1;
            byte_in      = frame_start;
            last_in      = 1'b0;
            idx_in       = etsf_pkg::BYTE_KIND;
            active_in    = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= etsf_pkg::BYTE_START;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_last_byte  = last_ff;

endmodule

`default_nettype wire

// ===== hdl/encoder_throttle_switch_framer_core.sv =====
// Top level of the encoder throttle and switch framer: configuration registers
// and the front end, frame queue and back end. Uses etsf_pkg and all etsf_ modules.
//
// The block takes one transaction per cycle while req_stall is low. Encoder edges
// update the count in the cycle they are accepted; a poll that changes anything goes
// through the throttle pipeline (wrap step, square, saturating add) into a four-entry
// frame queue; the byte serialiser sends the seven bytes in turn and sets the sustained
// rate, as it takes a new frame only after the last byte of the one before. The first
// byte passes the s1 and s2 registers, the queue and the output register. req_stall
// rises only when the queue and the pipeline together hold four frames. Configuration
// writes are always ready and take effect on the next frame byte that uses them.
`default_nettype none

module encoder_throttle_switch_framer_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [1:0]                      req_operation,
   input  wire logic [4:0]                      req_signal_pins,
   input  wire logic [4:0]                      req_nav_pins,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [7:0]                           rsp_frame_byte,
   output logic                                 rsp_last_byte,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [etsf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [7:0]                      csr_data
);

   logic [7:0] frame_start_ff, frame_start_in;
   logic [7:0] frame_kind_ff, frame_kind_in;
   logic       csr_write;

   etsf_pkg::push_type           push;
   etsf_pkg::head_type           head;
   logic                         pop;
   logic [etsf_pkg::QCNT_W-1:0]  queue_count;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      frame_start_in = frame_start_ff;
      frame_kind_in  = frame_kind_ff;
      if (csr_write) begin
         case (csr_index)
            etsf_pkg::CSR_FRAME_START: frame_start_in = csr_data;
            etsf_pkg::CSR_FRAME_KIND:  frame_kind_in  = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_start_ff <= etsf_pkg::RESET_FRAME_START;
         frame_kind_ff  <= etsf_pkg::RESET_FRAME_KIND;
      end else begin
         frame_start_ff <= frame_start_in;
         frame_kind_ff  <= frame_kind_in;
      end
   end

   etsf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_signal_pins (req_signal_pins),
      .req_nav_pins    (req_nav_pins),
      .queue_count     (queue_count),
      .push            (push)
   );

   etsf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .count (queue_count)
   );

   etsf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .frame_start    (frame_start_ff),
      .frame_kind     (frame_kind_ff),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule

`default_nettype wire
